@@ hdl/lbps_pkg.sv @@
// LED blink pattern sequencer: shared types and constants.
// No dependencies; used by the request interface, the step logic, the top level and the checker.
package lbps_pkg;

   localparam int unsigned PatternBits = 32;
   localparam int unsigned IndexBits   = 6;
   localparam int unsigned RepeatBits  = 8;

   // command codes
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_SET  = 1'b1;

   typedef logic [PatternBits-1:0] pattern_type;
   typedef logic [IndexBits-1:0]   index_type;
   typedef logic [RepeatBits-1:0]  repeat_type;

   typedef struct packed {
      index_type   bit_index;
      repeat_type  event_repeats_left;
      pattern_type background_pattern;
      pattern_type background_mask;
      pattern_type event_pattern;
      pattern_type event_mask;
      logic        led_lit;
   } lbps_state_type;

   localparam lbps_state_type StateReset = '{
      bit_index:          '0,
      event_repeats_left: '0,
      background_pattern: '0,
      background_mask:    '1,
      event_pattern:      '0,
      event_mask:         '1,
      led_lit:            1'b0
   };

endpackage

@@ hdl/lbps_req_if.sv @@
// Request channel of the LED blink pattern sequencer: valid/ready plus one item.
// Depends on lbps_pkg.
interface lbps_req_if;
   import lbps_pkg::*;

   logic        valid;
   logic        ready;
   logic        command;
   repeat_type  repeats;
   pattern_type new_pattern;
   pattern_type length_mask;

   modport source (output valid, command, repeats, new_pattern, length_mask,
                   input ready);
   modport sink   (input valid, command, repeats, new_pattern, length_mask,
                   output ready);
endinterface

@@ hdl/lbps_rsp_if.sv @@
// Response channel of the LED blink pattern sequencer: valid/ready plus one item.
// Does not depend on lbps_pkg; payload is plain bits.
interface lbps_rsp_if;
   logic valid;
   logic ready;
   logic led_on;
   logic pin_level;
   logic status;

   modport source (output valid, led_on, pin_level, status, input ready);
   modport sink   (input valid, led_on, pin_level, status, output ready);
endinterface

@@ hdl/lbps_step.sv @@
// Next-state logic for one item of the LED blink pattern sequencer.
// Depends on lbps_pkg.
module lbps_step (
   input  lbps_pkg::lbps_state_type state_cur,
   input  logic                     command,
   input  lbps_pkg::repeat_type     repeats,
   input  lbps_pkg::pattern_type    new_pattern,
   input  lbps_pkg::pattern_type    length_mask,
   output lbps_pkg::lbps_state_type state_next,
   output logic                     status
);
   import lbps_pkg::*;

   logic        event_sel;
   pattern_type sel_mask;
   logic        wrap;
   repeat_type  left_after;
   index_type   idx_use;
   pattern_type pat_use;
   logic        shown_bit;
   logic        mask_ok;
   pattern_type mask_plus;

   // tick path
   always_comb begin
      event_sel  = state_cur.event_repeats_left != '0;
      sel_mask   = event_sel ? state_cur.event_mask : state_cur.background_mask;
      // past the last pattern bit, or outside the active length
      wrap       = state_cur.bit_index[IndexBits-1] ||
                   !sel_mask[state_cur.bit_index[IndexBits-2:0]];
      left_after = (wrap && event_sel) ? state_cur.event_repeats_left - 1'b1
                                       : state_cur.event_repeats_left;
      idx_use    = wrap ? '0 : state_cur.bit_index;
      pat_use    = (left_after != '0) ? state_cur.event_pattern
                                      : state_cur.background_pattern;
      shown_bit  = pat_use[idx_use[IndexBits-2:0]];
   end

   // set path: mask must be nonzero low ones
   assign mask_plus = length_mask + 1'b1;
   assign mask_ok   = (length_mask != '0) && ((mask_plus & length_mask) == '0);

   always_comb begin
      state_next = state_cur;
      status     = 1'b0;
      unique case (command)
         CMD_TICK: begin
            state_next.event_repeats_left = left_after;
            state_next.led_lit            = shown_bit;
            state_next.bit_index          = idx_use + 1'b1;
         end
         CMD_SET: begin
            if (!mask_ok) begin
               status = 1'b1;
            end else begin
               if (repeats != '0) begin
                  state_next.event_pattern      = new_pattern;
                  state_next.event_mask         = length_mask;
                  state_next.event_repeats_left = repeats;
                  state_next.bit_index          = '0;
               end else begin
                  state_next.background_pattern = new_pattern;
                  state_next.background_mask    = length_mask;
                  if (state_cur.event_repeats_left == '0) begin
                     state_next.bit_index = '0;
                  end
               end
            end
         end
         default: begin
            state_next = state_cur;
         end
      endcase
   end

endmodule

@@ hdl/led_blink_pattern_sequencer.sv @@
// LED blink pattern sequencer, top level: state registers, result register, csr.
// The result is valid in the cycle after item acceptance; throughput 1 item/cycle.
// The result register frees while being drained, so req ready stays high unless
// a result is held by a stalled sink. Synchronous active-high reset returns the
// patterns to off with full-length masks, clears the index, repeats, LED and
// active_low, and empties the result register. Depends on lbps_pkg, lbps_step.
module led_blink_pattern_sequencer (
   input  logic        clock,
   input  logic        reset,
   lbps_req_if.sink    req_chan,
   lbps_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic        csr_wdata
);
   import lbps_pkg::*;

   lbps_state_type state_ff, state_in, step_next;
   logic           step_status;
   logic           active_low_ff, active_low_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           led_on_ff, led_on_in;
   logic           pin_level_ff, pin_level_in;
   logic           status_ff, status_in;
   logic           accept;

   // one item's whole step is this block of logic
   lbps_step u_step (
      .state_cur   (state_ff),
      .command     (req_chan.command),
      .repeats     (req_chan.repeats),
      .new_pattern (req_chan.new_pattern),
      .length_mask (req_chan.length_mask),
      .state_next  (step_next),
      .status      (step_status)
   );

   // take a new item whenever the result slot is empty or being drained
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in      = accept ? step_next : state_ff;
      active_low_in = csr_we ? csr_wdata : active_low_ff;
      rsp_valid_in  = accept || (rsp_valid_ff && !rsp_chan.ready);
      // payload: load on accept, otherwise hold
      led_on_in     = accept ? step_next.led_lit : led_on_ff;
      pin_level_in  = accept ? (step_next.led_lit ^ active_low_ff) : pin_level_ff;
      status_in     = accept ? step_status : status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= StateReset;
         active_low_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_low_ff <= active_low_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload needs no reset
   always_ff @(posedge clock) begin
      led_on_ff    <= led_on_in;
      pin_level_ff <= pin_level_in;
      status_ff    <= status_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.led_on    = led_on_ff;
   assign rsp_chan.pin_level = pin_level_ff;
   assign rsp_chan.status    = status_ff;

endmodule

@@ hdl/lbps_checker.sv @@
// Port-level checks for the LED blink pattern sequencer, bound to the top level.
// Depends on lbps_pkg and led_blink_pattern_sequencer.
module lbps_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_command,
   input lbps_pkg::pattern_type req_length_mask,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_status
);
   import lbps_pkg::*;

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a tick always answers next cycle with ok status
   a_tick_ok: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == CMD_TICK |=> rsp_valid && !rsp_status)
      else $error("tick result missing or flagged");

   // a zero mask is rejected
   a_zero_mask: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == CMD_SET && req_length_mask == '0
      |=> rsp_valid && rsp_status)
      else $error("zero mask not rejected");

endmodule

bind led_blink_pattern_sequencer lbps_checker u_lbps_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_command     (req_chan.command),
   .req_length_mask (req_chan.length_mask),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status)
);
